/* design/p2a_pkg.sv */
// Shared types, constants and tables for the pressure to altitude pipeline.
package p2a_pkg;

  localparam int FRAC_BITS    = 30;
  localparam int LOG_TERMS_DEF = 28;
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [19:0] REF_RESET    = 20'd101325;
  localparam logic [27:0] POWER_Q30    = 28'd204293453;
  localparam logic [22:0] SCALE_CM     = 23'd4433077;
  localparam logic [33:0] CLAMP_Q30    = 34'(8) << FRAC_BITS;
  localparam logic [30:0] ONE_Q30      = 31'(1) << FRAC_BITS;
  localparam logic [63:0] ROUND_HALF   = 64'(1) << (FRAC_BITS - 1);

  localparam logic [29:0] LG_TAB [31] = '{
    30'd0, 30'd628098702, 30'd345667660, 30'd182455581, 30'd93912511, 30'd47667823,
    30'd24017256, 30'd12055174, 30'd6039314, 30'd3022600, 30'd1512037, 30'd756203,
    30'd378148, 30'd189085, 30'd94546, 30'd47274, 30'd23637, 30'd11819, 30'd5909,
    30'd2955, 30'd1477, 30'd739, 30'd369, 30'd185, 30'd92, 30'd46, 30'd23, 30'd12,
    30'd6, 30'd3, 30'd1
  };

  typedef struct packed {
    logic        zero_ref;
    logic [30:0] mp;
    logic [30:0] mr;
    logic [4:0]  ep;
    logic [4:0]  er;
    logic [30:0] accp;
    logic [30:0] accr;
    logic        neg;
    logic [34:0] lr_mag;
    logic [44:0] pp_hi;
    logic [45:0] pp_lo;
    logic [4:0]  whole;
    logic [29:0] frac;
    logic [30:0] mant;
    logic [38:0] om_mag;
    logic [41:0] sc_hi;
    logic [42:0] sc_lo;
    logic [27:0] altitude;
  } item_t;

endpackage

/* design/p2a_in_if.sv */
// Pressure sample channel.
interface p2a_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] pressure;
  modport source (output valid, input ready, output pressure);
  modport sink (input valid, output ready, input pressure);
endinterface

/* design/p2a_out_if.sv */
// Altitude result channel.
interface p2a_out_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] altitude;
  modport source (output valid, input ready, output altitude);
  modport sink (input valid, output ready, input altitude);
endinterface

/* design/p2a_pipe_reg.sv */
// One pipeline register with valid bit and per-stage flow control.
module p2a_pipe_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  p2a_pkg::item_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output p2a_pkg::item_t dn_data
);
  import p2a_pkg::*;

  logic  valid_r;
  item_t data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end
endmodule

/* design/p2a_log_stage.sv */
// A group of digit-by-digit log2 steps on the sample and reference lanes.
module p2a_log_stage #(
  parameter int FIRST = 1,
  parameter int LAST  = 4
) (
  input  p2a_pkg::item_t i_item,
  output p2a_pkg::item_t o_item
);
  import p2a_pkg::*;

  logic [31:0] s_p;
  logic [31:0] s_r;

  always_comb begin
    o_item = i_item;
    s_p    = '0;
    s_r    = '0;
    for (int k = FIRST; k <= LAST; k++) begin
      s_p = {1'b0, o_item.mp} + {1'b0, o_item.mp >> k};
      if (!s_p[31]) begin
        o_item.mp   = s_p[30:0];
        o_item.accp = o_item.accp + {1'b0, LG_TAB[k]};
      end
      s_r = {1'b0, o_item.mr} + {1'b0, o_item.mr >> k};
      if (!s_r[31]) begin
        o_item.mr   = s_r[30:0];
        o_item.accr = o_item.accr + {1'b0, LG_TAB[k]};
      end
    end
  end
endmodule

/* design/p2a_exp_stage.sv */
// A group of digit-by-digit exp2 steps on the fractional exponent.
module p2a_exp_stage #(
  parameter int FIRST = 1,
  parameter int LAST  = 4
) (
  input  p2a_pkg::item_t i_item,
  output p2a_pkg::item_t o_item
);
  import p2a_pkg::*;

  always_comb begin
    o_item = i_item;
    for (int k = FIRST; k <= LAST; k++) begin
      if (o_item.frac >= LG_TAB[k]) begin
        o_item.frac = o_item.frac - LG_TAB[k];
        o_item.mant = o_item.mant + (o_item.mant >> k);
      end
    end
  end
endmodule

/* design/pressure_to_altitude.sv */
// Top level: pipelined barometric altitude from pressure and reference pressure.
//
//   channel  dir  payload                   handshake
//   in_chan  in   pressure [19:0] unsigned  valid/ready
//   out_chan out  altitude [27:0] signed    valid/ready
//   cfg      in   cfg_wdata [19:0]          cfg_we, no back-pressure
//
// One transaction enters per cycle unless a stall holds the pipeline; the log2 and
// exp2 steps are grouped into stages of four steps per stage.
// Synchronous active-low reset empties the pipeline and loads 101325 Pa.
// Each stage holds on stall and takes new data when empty or once its successor frees up.
module pressure_to_altitude #(
  parameter int LOG_TERMS = p2a_pkg::LOG_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  p2a_in_if.sink      in_chan,
  p2a_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);
  import p2a_pkg::*;

  localparam int NL     = (LOG_TERMS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int S_DIFF = NL + 1;
  localparam int S_MUL1 = NL + 2;
  localparam int S_MUL2 = NL + 3;
  localparam int S_EXP0 = NL + 4;
  localparam int S_SHFT = 2 * NL + 4;
  localparam int S_SC1  = 2 * NL + 5;
  localparam int S_SC2  = 2 * NL + 6;
  localparam int NS     = 2 * NL + 7;

  logic [19:0] ref_r;
  item_t       stg_in  [NS];
  item_t       stg_out [NS];
  logic        vld     [NS];
  logic        rdy     [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (cfg_we) begin
      ref_r <= cfg_wdata;
    end
  end

  // normalise both operands
  logic [19:0] vp, vr;
  logic [4:0]  bp, br;
  always_comb begin
    stg_in[0] = '0;
    vp = (in_chan.pressure == '0) ? 20'd1 : in_chan.pressure;
    vr = (ref_r == '0) ? 20'd1 : ref_r;
    bp = '0;
    br = '0;
    for (int j = 0; j < 20; j++) begin
      if (vp[j]) bp = 5'(j);
      if (vr[j]) br = 5'(j);
    end
    stg_in[0].zero_ref = (ref_r == '0);
    stg_in[0].mp = {11'b0, vp} << (5'd30 - bp);
    stg_in[0].mr = {11'b0, vr} << (5'd30 - br);
    stg_in[0].ep = bp + 5'd1;
    stg_in[0].er = br + 5'd1;
  end

  genvar k;
  generate
    for (k = 1; k <= NL; k++) begin : g_log
      localparam int LAST = (STEPS_PER_STAGE * k < LOG_TERMS) ?
                            STEPS_PER_STAGE * k : LOG_TERMS;
      p2a_log_stage #(.FIRST(STEPS_PER_STAGE * (k - 1) + 1), .LAST(LAST)) u_log (
        .i_item(stg_out[k-1]),
        .o_item(stg_in[k])
      );
    end
    for (k = 1; k <= NL; k++) begin : g_exp
      localparam int LAST = (STEPS_PER_STAGE * k < LOG_TERMS) ?
                            STEPS_PER_STAGE * k : LOG_TERMS;
      p2a_exp_stage #(.FIRST(STEPS_PER_STAGE * (k - 1) + 1), .LAST(LAST)) u_exp (
        .i_item(stg_out[S_EXP0+k-2]),
        .o_item(stg_in[S_EXP0+k-1])
      );
    end
  endgenerate

  // log difference and magnitude
  logic signed [36:0] lr;
  logic signed [5:0]  de;
  always_comb begin
    stg_in[S_DIFF] = stg_out[S_DIFF-1];
    de = $signed({1'b0, stg_out[S_DIFF-1].ep}) - $signed({1'b0, stg_out[S_DIFF-1].er});
    lr = $signed({de, 30'b0}) - $signed({6'b0, stg_out[S_DIFF-1].accp})
         + $signed({6'b0, stg_out[S_DIFF-1].accr});
    stg_in[S_DIFF].neg    = lr[36];
    stg_in[S_DIFF].lr_mag = lr[36] ? 35'(-lr) : lr[34:0];
  end

  always_comb begin
    stg_in[S_MUL1] = stg_out[S_MUL1-1];
    stg_in[S_MUL1].pp_hi = stg_out[S_MUL1-1].lr_mag[34:18] * POWER_Q30;
    stg_in[S_MUL1].pp_lo = stg_out[S_MUL1-1].lr_mag[17:0] * POWER_Q30;
  end

  // truncate, clamp, split into whole and fraction
  logic [63:0] psum;
  logic [33:0] prod;
  logic [34:0] ex;
  always_comb begin
    stg_in[S_MUL2] = stg_out[S_MUL2-1];
    psum = {1'b0, stg_out[S_MUL2-1].pp_hi, 18'b0} + {18'b0, stg_out[S_MUL2-1].pp_lo};
    prod = psum[63:30];
    if (prod > CLAMP_Q30) prod = CLAMP_Q30;
    ex = stg_out[S_MUL2-1].neg ? -{1'b0, prod} : {1'b0, prod};
    stg_in[S_MUL2].whole = ex[34:30];
    stg_in[S_MUL2].frac  = ex[29:0];
    stg_in[S_MUL2].mant  = ONE_Q30;
  end

  // whole shift, then one minus power
  logic [38:0]        pw;
  logic signed [39:0] om;
  logic [4:0]         nwhole;
  always_comb begin
    stg_in[S_SHFT] = stg_out[S_SHFT-1];
    nwhole = -stg_out[S_SHFT-1].whole;
    if (!stg_out[S_SHFT-1].whole[4]) begin
      pw = {8'b0, stg_out[S_SHFT-1].mant} << stg_out[S_SHFT-1].whole[3:0];
    end else begin
      pw = {8'b0, stg_out[S_SHFT-1].mant} >> nwhole;
    end
    om = $signed({9'b0, ONE_Q30}) - $signed({1'b0, pw});
    stg_in[S_SHFT].neg    = om[39];
    stg_in[S_SHFT].om_mag = om[39] ? 39'(-om) : om[38:0];
  end

  always_comb begin
    stg_in[S_SC1] = stg_out[S_SC1-1];
    stg_in[S_SC1].sc_hi = stg_out[S_SC1-1].om_mag[38:20] * SCALE_CM;
    stg_in[S_SC1].sc_lo = stg_out[S_SC1-1].om_mag[19:0] * SCALE_CM;
  end

  // round half up, restore sign; zero altitude when the reference is zero
  logic [63:0] ssum;
  logic [27:0] amag;
  always_comb begin
    stg_in[S_SC2] = stg_out[S_SC2-1];
    ssum = {2'b0, stg_out[S_SC2-1].sc_hi, 20'b0} + {21'b0, stg_out[S_SC2-1].sc_lo}
           + ROUND_HALF;
    amag = ssum[57:30];
    if (stg_out[S_SC2-1].zero_ref) begin
      stg_in[S_SC2].altitude = '0;
    end else begin
      stg_in[S_SC2].altitude = stg_out[S_SC2-1].neg ? -amag : amag;
    end
  end

  generate
    for (k = 0; k < NS; k++) begin : g_reg
      if (k == 0) begin : g_first
        p2a_pipe_reg u_reg (
          .clk(clk), .rst_n(rst_n),
          .up_valid(in_chan.valid), .up_ready(rdy[k]), .up_data(stg_in[k]),
          .dn_valid(vld[k]), .dn_ready(rdy[k+1]), .dn_data(stg_out[k])
        );
      end else if (k == NS - 1) begin : g_last
        p2a_pipe_reg u_reg (
          .clk(clk), .rst_n(rst_n),
          .up_valid(vld[k-1]), .up_ready(rdy[k]), .up_data(stg_in[k]),
          .dn_valid(vld[k]), .dn_ready(out_chan.ready), .dn_data(stg_out[k])
        );
      end else begin : g_mid
        p2a_pipe_reg u_reg (
          .clk(clk), .rst_n(rst_n),
          .up_valid(vld[k-1]), .up_ready(rdy[k]), .up_data(stg_in[k]),
          .dn_valid(vld[k]), .dn_ready(rdy[k+1]), .dn_data(stg_out[k])
        );
      end
    end
  endgenerate

  assign in_chan.ready     = rdy[0];
  assign out_chan.valid    = vld[NS-1];
  assign out_chan.altitude = $signed(stg_out[NS-1].altitude);
endmodule

/* sim/tb_pressure_to_altitude.sv */
// Testbench for the pressure to altitude pipeline: directed and random samples checked against a Q30 predictor.
`timescale 1ns / 1ps
module tb_pressure_to_altitude;
  import p2a_pkg::*;

  localparam int LATENCY = 2 * ((LOG_TERMS_DEF + 3) / 4) + 7;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [19:0] cfg_wdata;

  p2a_in_if in_chan ();
  p2a_out_if out_chan ();

  pressure_to_altitude dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [19:0] ref_pressure;
  logic signed [27:0] expected_altitudes[$];
  int mismatches;
  int cycles;
  bit sender_idles;
  bit receiver_idles;
  int hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint log2_fix(logic [31:0] v);
    logic [31:0] m;
    logic [31:0] s;
    longint sh;
    logic [31:0] acc;
    m = (v == 0) ? 32'd1 : v;
    sh = 0;
    acc = 0;
    while (m < 32'h4000_0000) begin
      m = m << 1;
      sh++;
    end
    for (int i = 1; i <= LOG_TERMS_DEF; i++) begin
      s = m + (m >> i);
      if (s < 32'h8000_0000) begin
        m = s;
        acc = acc + LG_TAB[i];
      end
    end
    return (31 - sh) * (longint'(1) << 30) - longint'(acc);
  endfunction

  function automatic logic [31:0] exp2_fix(logic [31:0] f);
    logic [31:0] r;
    r = 32'h4000_0000;
    for (int i = 1; i <= LOG_TERMS_DEF; i++) begin
      if (f >= LG_TAB[i]) begin
        f = f - LG_TAB[i];
        r = r + (r >> i);
      end
    end
    return r;
  endfunction

  function automatic logic signed [27:0] predict_altitude(logic [19:0] p, logic [19:0] pref);
    longint lr;
    longint ex;
    longint biased;
    longint whole;
    longint pw;
    longint om;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [31:0] mant;
    bit neg;
    if (pref == 0) return '0;
    lr = log2_fix(p == 0 ? 20'd1 : p) - log2_fix(pref);
    neg = lr < 0;
    mag = neg ? -lr : lr;
    prod = (mag * 64'd204293453) >> 30;
    ex = neg ? -longint'(prod) : longint'(prod);
    if (ex > (longint'(8) << 30)) ex = longint'(8) << 30;
    if (ex < -(longint'(8) << 30)) ex = -(longint'(8) << 30);
    biased = ex + (longint'(8) << 30);
    whole = (biased >>> 30) - 8;
    mant = exp2_fix(32'(biased & ((longint'(1) << 30) - 1)));
    pw = (whole >= 0) ? (longint'(mant) << whole) : (longint'(mant) >> (-whole));
    om = (longint'(1) << 30) - pw;
    mag = (om < 0) ? -om : om;
    mag = (mag * 64'd4433077 + (64'd1 << 29)) >> 30;
    return (om < 0) ? 28'(-longint'(mag)) : 28'(mag);
  endfunction

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver side: random stalls, or a long hold-off when requested
  initial begin
    int burst;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        out_chan.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    logic signed [27:0] want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_altitudes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected altitude %0d", out_chan.altitude);
      end else begin
        want = expected_altitudes.pop_front();
        if (out_chan.altitude !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("altitude mismatch: expected %0d actual %0d", want, out_chan.altitude);
        end
      end
    end
  end

  task automatic send_pressure(logic [19:0] p);
    int burst;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 11);
      in_chan.valid <= 1'b0;
      repeat (burst) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.pressure <= p;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_altitudes.push_back(predict_altitude(p, ref_pressure));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (expected_altitudes.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reference(logic [19:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_pressure = value;
  endtask

  function automatic logic [19:0] random_pressure();
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(30000, 110000));
      2: return 20'($urandom_range(0, 16));
      default: return 20'($urandom_range(1040000, 1048575));
    endcase
  endfunction

  task automatic test_directed_extremes();
    logic [19:0] corners[] = '{20'd0, 20'd1, 20'd2, 20'd101325, 20'd101324, 20'd101326,
                               20'd1048575, 20'd524288, 20'd524287, 20'd65536, 20'd50000,
                               20'hAAAAA, 20'h55555, 20'd1000, 20'd200000};
    foreach (corners[i]) send_pressure(corners[i]);
    write_reference(20'd0);
    send_pressure(20'd0);
    send_pressure(20'd1048575);
    send_pressure(20'd101325);
    write_reference(20'd1);
    send_pressure(20'd0);
    send_pressure(20'd1048575);
    write_reference(20'd1048575);
    send_pressure(20'd0);
    send_pressure(20'd1048575);
    send_pressure(20'd1);
  endtask

  task automatic test_random_references();
    for (int phase = 0; phase < 6; phase++) begin
      write_reference(phase == 0 ? 20'd101325 : 20'($urandom));
      repeat (150) send_pressure(random_pressure());
    end
  endtask

  task automatic test_back_pressure();
    write_reference(20'd90000);
    hold_off_cycles = 200;
    repeat (100) send_pressure(random_pressure());
    drain();
    repeat (100) send_pressure(random_pressure());
  endtask

  task automatic test_full_rate();
    write_reference(20'($urandom_range(1, 1048575)));
    sender_idles = 0;
    receiver_idles = 0;
    repeat (400) send_pressure(random_pressure());
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.pressure <= '0;
    ref_pressure = REF_RESET;
    mismatches = 0;
    hold_off_cycles = 0;
    sender_idles = 1;
    receiver_idles = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_references();
    test_back_pressure();
    test_full_rate();
    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
